// ===== sv/hit_alignment_correction_core_assert.svh =====
// Assertion macros shared by the hit alignment correction RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef HIT_ALIGNMENT_CORRECTION_CORE_ASSERT_SVH
`define HIT_ALIGNMENT_CORRECTION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HAC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HAC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/hac_pkg.sv =====
// Types and constants of the hit alignment correction block.
// No dependencies.
package hac_pkg;

  localparam logic [1:0] MODE_PLANE = 2'd0;
  localparam logic [1:0] MODE_ALIGN = 2'd1;
  localparam logic [1:0] MODE_HIT   = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] ST_ALIGNED = 2'd0;
  localparam logic [1:0] ST_COPIED  = 2'd1;
  localparam logic [1:0] ST_FAR     = 2'd2;

  localparam logic [1:0] REG_PLANE_COUNT = 2'd0;
  localparam logic [1:0] REG_ALIGN_COUNT = 2'd1;
  localparam logic [1:0] REG_MAX_DIST    = 2'd2;

  localparam logic [30:0] MAX_DIST_RESET = 31'd327680;

  typedef struct packed {
    logic        have;
    logic [32:0] span;
    logic [7:0]  sensor;
  } hac_node_t;

  typedef struct packed {
    logic               vld;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } hac_hit_t;

endpackage

// ===== sv/hac_in_if.sv =====
// Input channel of the hit alignment correction block: valid, ready, item.
// No dependencies.
interface hac_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [3:0]         slot;
  logic [7:0]         sensor_id;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] alpha;
  logic signed [31:0] beta;
  logic signed [31:0] gamma;
  logic signed [31:0] shift_x;
  logic signed [31:0] shift_y;
  logic signed [31:0] shift_z;
  modport source (output valid, mode, slot, sensor_id, pos_x, pos_y, pos_z, alpha, beta,
                  gamma, shift_x, shift_y, shift_z, input ready);
  modport sink (input valid, mode, slot, sensor_id, pos_x, pos_y, pos_z, alpha, beta,
                gamma, shift_x, shift_y, shift_z, output ready);
endinterface

// ===== sv/hac_out_if.sv =====
// Result channel of the hit alignment correction block: valid, ready, item.
// No dependencies.
interface hac_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic [7:0]         hit_sensor;
  logic [1:0]         status;
  modport source (output valid, out_x, out_y, out_z, hit_sensor, status, input ready);
  modport sink (input valid, out_x, out_y, out_z, hit_sensor, status, output ready);
endinterface

// ===== sv/hac_nearest.sv =====
// Nearest plane search: distance stage followed by a registered minimum tree.
// Depends on hac_pkg.
module hac_nearest #(
  parameter int MAX_PLANES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                hit_in,
  input  logic signed [31:0]  x_in,
  input  logic signed [31:0]  y_in,
  input  logic signed [31:0]  z_in,
  input  logic [6:0]          np,
  input  logic signed [31:0]  pz [MAX_PLANES],
  input  logic [7:0]          ps [MAX_PLANES],
  output hac_pkg::hac_node_t  best,
  output hac_pkg::hac_hit_t   hit_out,
  output logic                busy
);
  import hac_pkg::*;

  localparam int L = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int P = 1 << L;

  hac_node_t node_r [0:L][P];
  hac_node_t node_nxt [0:L][P];
  hac_hit_t  hp_r [0:L];
  hac_hit_t  hp_nxt [0:L];

  always_comb begin
    logic signed [32:0] d;
    for (int j = 0; j < P; j++) begin
      node_nxt[0][j] = '0;
      if (j < MAX_PLANES) begin
        d = 33'(z_in) - 33'(pz[j]);
        node_nxt[0][j].have = (7'(j) < np);
        node_nxt[0][j].span = d[32] ? 33'(-d) : 33'(d);
        node_nxt[0][j].sensor = ps[j];
      end
    end
    for (int k = 1; k <= L; k++) begin
      for (int j = 0; j < P; j++) begin
        node_nxt[k][j] = '0;
        if (j < (P >> k)) begin
          if (node_r[k-1][2*j+1].have &&
              (!node_r[k-1][2*j].have || node_r[k-1][2*j+1].span < node_r[k-1][2*j].span)) begin
            node_nxt[k][j] = node_r[k-1][2*j+1];
          end else begin
            node_nxt[k][j] = node_r[k-1][2*j];
          end
        end
      end
    end
    hp_nxt[0] = '{vld: hit_in, x: x_in, y: y_in, z: z_in};
    for (int k = 1; k <= L; k++) begin
      hp_nxt[k] = hp_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      node_r <= node_nxt;
      for (int k = 0; k <= L; k++) begin
        hp_r[k].x <= hp_nxt[k].x;
        hp_r[k].y <= hp_nxt[k].y;
        hp_r[k].z <= hp_nxt[k].z;
      end
    end
    if (!rst_n) begin
      for (int k = 0; k <= L; k++) hp_r[k].vld <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k <= L; k++) hp_r[k].vld <= hp_nxt[k].vld;
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int k = 0; k <= L; k++) busy = busy | hp_r[k].vld;
  end

  assign best    = node_r[L][0];
  assign hit_out = hp_r[L];

  `include "hit_alignment_correction_core_assert.svh"
  `HAC_ASSERT_NEXT(a_stall_holds, !adv, hp_r[L].vld == $past(hp_r[L].vld))
  `HAC_ASSERT_NEXT(a_hit_enters, adv && hit_in, hp_r[0].vld)
  `HAC_ASSERT_SAME(a_busy_cover, hp_r[L].vld, busy)
endmodule

// ===== sv/hit_alignment_correction_core.sv =====
// Hit alignment correction block: plane assignment, alignment lookup and
// small-angle correction of tracker hits. Depends on hac_pkg, hac_in_if,
// hac_out_if and hac_nearest.
//
// Usage: items enter on in_ch. Mode 0 loads a plane entry, mode 1 an
// alignment entry, mode 2 is a hit; only a hit gives a result on out_ch.
// Registers (plane_count, align_count, max_distance) are written over the
// APB port at byte addresses 0, 4 and 8. The user must write them only
// while the block is idle; the block itself does not enforce this. A hit
// passes one distance stage, the registered minimum tree, the lookup stage,
// the multiplier stage, the rounding stage and the output register.
// A hit or plane load may enter every cycle while the pipeline is not held.
// An alignment load waits until no hit is ahead of the lookup stage.
// When out_ch.ready is low with a result waiting, the whole pipeline holds
// and in_ch.ready falls; nothing is lost or repeated.
// Reset clears the registers to their defaults and empties the pipeline;
// table contents are undefined until loaded.
module hit_alignment_correction_core #(
  parameter int MAX_PLANES = 16,
  parameter int MAX_ALIGN  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  hac_in_if.sink      in_ch,
  hac_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hac_pkg::*;

  logic [4:0]  plane_count_r;
  logic [4:0]  align_count_r;
  logic [30:0] max_dist_r;
  logic [6:0]  np;
  logic [6:0]  na;

  logic signed [31:0] pz_r [MAX_PLANES];
  logic [7:0]         ps_r [MAX_PLANES];
  logic [7:0]         as_r [MAX_ALIGN];
  logic signed [31:0] aa_r [MAX_ALIGN];
  logic signed [31:0] ab_r [MAX_ALIGN];
  logic signed [31:0] ag_r [MAX_ALIGN];
  logic signed [31:0] ax_r [MAX_ALIGN];
  logic signed [31:0] ay_r [MAX_ALIGN];
  logic signed [31:0] az_r [MAX_ALIGN];

  logic      adv, busy, acc;
  hac_node_t best;
  hac_hit_t  nh;

  // APB register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= '0;
      align_count_r <= '0;
      max_dist_r    <= MAX_DIST_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_PLANE_COUNT: plane_count_r <= pwdata[4:0];
        REG_ALIGN_COUNT: align_count_r <= pwdata[4:0];
        REG_MAX_DIST:    max_dist_r    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PLANE_COUNT: prdata = {27'd0, plane_count_r};
      REG_ALIGN_COUNT: prdata = {27'd0, align_count_r};
      REG_MAX_DIST:    prdata = {1'b0, max_dist_r};
      default:         prdata = '0;
    endcase
  end

  assign np = ({2'd0, plane_count_r} > 7'(MAX_PLANES)) ? 7'(MAX_PLANES)
                                                        : {2'd0, plane_count_r};
  assign na = ({2'd0, align_count_r} > 7'(MAX_ALIGN)) ? 7'(MAX_ALIGN)
                                                       : {2'd0, align_count_r};

  // Handshake: every stage moves together when the output register is empty or its result is taken.
  logic out_vld_r;
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv && !(in_ch.mode == MODE_ALIGN && busy);
  assign acc = in_ch.valid && in_ch.ready;

  // Table loads
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PLANES; i++) begin
      if (acc && in_ch.mode == MODE_PLANE && 7'(in_ch.slot) == 7'(i)) begin
        pz_r[i] <= in_ch.pos_z;
        ps_r[i] <= in_ch.sensor_id;
      end
    end
    for (int i = 0; i < MAX_ALIGN; i++) begin
      if (acc && in_ch.mode == MODE_ALIGN && 7'(in_ch.slot) == 7'(i)) begin
        as_r[i] <= in_ch.sensor_id;
        aa_r[i] <= in_ch.alpha;
        ab_r[i] <= in_ch.beta;
        ag_r[i] <= in_ch.gamma;
        ax_r[i] <= in_ch.shift_x;
        ay_r[i] <= in_ch.shift_y;
        az_r[i] <= in_ch.shift_z;
      end
    end
  end

  hac_nearest #(.MAX_PLANES(MAX_PLANES)) u_nearest (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .hit_in  (acc && in_ch.mode == MODE_HIT),
    .x_in    (in_ch.pos_x),
    .y_in    (in_ch.pos_y),
    .z_in    (in_ch.pos_z),
    .np      (np),
    .pz      (pz_r),
    .ps      (ps_r),
    .best    (best),
    .hit_out (nh),
    .busy    (busy)
  );

  // Lookup stage
  logic               t_vld_r, t_vld_nxt;
  logic [1:0]         t_st_r, t_st_nxt;
  logic [7:0]         t_sen_r, t_sen_nxt;
  logic signed [31:0] t_x_r, t_y_r, t_z_r;
  logic signed [31:0] t_a_r, t_b_r, t_g_r, t_sx_r, t_sy_r, t_sz_r;
  logic signed [31:0] t_a_nxt, t_b_nxt, t_g_nxt, t_sx_nxt, t_sy_nxt, t_sz_nxt;

  always_comb begin
    logic found;
    found     = 1'b0;
    t_a_nxt   = '0;
    t_b_nxt   = '0;
    t_g_nxt   = '0;
    t_sx_nxt  = '0;
    t_sy_nxt  = '0;
    t_sz_nxt  = '0;
    t_vld_nxt = nh.vld;
    t_sen_nxt = best.have ? best.sensor : 8'd0;
    for (int i = 0; i < MAX_ALIGN; i++) begin
      if (7'(i) < na && as_r[i] == best.sensor) begin
        found    = 1'b1;
        t_a_nxt  = aa_r[i];
        t_b_nxt  = ab_r[i];
        t_g_nxt  = ag_r[i];
        t_sx_nxt = ax_r[i];
        t_sy_nxt = ay_r[i];
        t_sz_nxt = az_r[i];
      end
    end
    if (!best.have || best.span > {2'd0, max_dist_r}) begin
      t_st_nxt = ST_FAR;
    end else if (found) begin
      t_st_nxt = ST_ALIGNED;
    end else begin
      t_st_nxt = ST_COPIED;
    end
  end

  // Multiplier stage
  logic               m_vld_r;
  logic [1:0]         m_st_r;
  logic [7:0]         m_sen_r;
  logic signed [31:0] m_x_r, m_y_r, m_z_r, m_sx_r, m_sy_r, m_sz_r;
  logic signed [63:0] m_pax_r, m_pgy_r, m_pby_r, m_pgx_r;

  // Rounding stage
  logic               s_vld_r;
  logic [1:0]         s_st_r;
  logic [7:0]         s_sen_r;
  logic signed [31:0] s_x_r, s_y_r, s_z_r, s_sx_r, s_sy_r, s_sz_r;
  logic signed [34:0] s_cx_r, s_cy_r, s_cx_nxt, s_cy_nxt;

  always_comb begin
    logic signed [64:0] sumx, sumy;
    sumx = 65'(m_pax_r) + 65'(m_pgy_r) + 65'sd536870912;
    sumy = 65'(m_pby_r) - 65'(m_pgx_r) + 65'sd536870912;
    s_cx_nxt = 35'(sumx >>> 30);
    s_cy_nxt = 35'(sumy >>> 30);
  end

  // Output stage
  logic signed [31:0] o_x_r, o_y_r, o_z_r, o_x_nxt, o_y_nxt, o_z_nxt;
  logic [7:0]         o_sen_r;
  logic [1:0]         o_st_r;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'sh7fffffff;
    if (v < -37'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    if (s_st_r == ST_ALIGNED) begin
      o_x_nxt = sat32(37'(s_x_r) + 37'(s_cx_r) - 37'(s_sx_r));
      o_y_nxt = sat32(37'(s_y_r) + 37'(s_cy_r) - 37'(s_sy_r));
      o_z_nxt = sat32(37'(s_z_r) - 37'(s_sz_r));
    end else begin
      o_x_nxt = s_x_r;
      o_y_nxt = s_y_r;
      o_z_nxt = s_z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_st_r  <= t_st_nxt;
      t_sen_r <= t_sen_nxt;
      t_x_r   <= nh.x;
      t_y_r   <= nh.y;
      t_z_r   <= nh.z;
      t_a_r   <= t_a_nxt;
      t_b_r   <= t_b_nxt;
      t_g_r   <= t_g_nxt;
      t_sx_r  <= t_sx_nxt;
      t_sy_r  <= t_sy_nxt;
      t_sz_r  <= t_sz_nxt;

      m_st_r  <= t_st_r;
      m_sen_r <= t_sen_r;
      m_x_r   <= t_x_r;
      m_y_r   <= t_y_r;
      m_z_r   <= t_z_r;
      m_sx_r  <= t_sx_r;
      m_sy_r  <= t_sy_r;
      m_sz_r  <= t_sz_r;
      m_pax_r <= 64'(t_a_r) * 64'(t_x_r);
      m_pgy_r <= 64'(t_g_r) * 64'(t_y_r);
      m_pby_r <= 64'(t_b_r) * 64'(t_y_r);
      m_pgx_r <= 64'(t_g_r) * 64'(t_x_r);

      s_st_r  <= m_st_r;
      s_sen_r <= m_sen_r;
      s_x_r   <= m_x_r;
      s_y_r   <= m_y_r;
      s_z_r   <= m_z_r;
      s_sx_r  <= m_sx_r;
      s_sy_r  <= m_sy_r;
      s_sz_r  <= m_sz_r;
      s_cx_r  <= s_cx_nxt;
      s_cy_r  <= s_cy_nxt;

      o_x_r   <= o_x_nxt;
      o_y_r   <= o_y_nxt;
      o_z_r   <= o_z_nxt;
      o_sen_r <= s_sen_r;
      o_st_r  <= s_st_r;
    end
    if (!rst_n) begin
      t_vld_r   <= 1'b0;
      m_vld_r   <= 1'b0;
      s_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      t_vld_r   <= t_vld_nxt;
      m_vld_r   <= t_vld_r;
      s_vld_r   <= m_vld_r;
      out_vld_r <= s_vld_r;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.out_x      = o_x_r;
  assign out_ch.out_y      = o_y_r;
  assign out_ch.out_z      = o_z_r;
  assign out_ch.hit_sensor = o_sen_r;
  assign out_ch.status     = o_st_r;

  `include "hit_alignment_correction_core_assert.svh"
  `HAC_ASSERT_SAME(a_align_load_idle, acc && in_ch.mode == MODE_ALIGN, !busy)
  `HAC_ASSERT_NEXT(a_out_held, out_vld_r && !out_ch.ready, out_vld_r && $stable(o_x_r))
  `HAC_ASSERT_SAME(a_status_code, out_vld_r,
                   o_st_r == ST_ALIGNED || o_st_r == ST_COPIED || o_st_r == ST_FAR)
endmodule
